### rtl/bilinear_scanout_resampler_unit_macros.svh
`ifndef BILINEAR_SCANOUT_RESAMPLER_UNIT_MACROS_SVH
`define BILINEAR_SCANOUT_RESAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BSR_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bsr check failed");

// Next-cycle implication, checked outside reset.
`define BSR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bsr check failed");

`endif

### rtl/bsr_pkg.sv
package bsr_pkg;

   localparam int MAX_SOURCE_COLUMNS = 1024;
   localparam int COL_W = 10;
   localparam int ADDR_W = COL_W + 1;

   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_REQUEST = 1'b1;

   localparam logic [2:0] REG_X_START     = 3'd0;
   localparam logic [2:0] REG_X_STEP      = 3'd1;
   localparam logic [2:0] REG_Y_START     = 3'd2;
   localparam logic [2:0] REG_Y_STEP      = 3'd3;
   localparam logic [2:0] REG_VIEW_FIRST  = 3'd4;
   localparam logic [2:0] REG_VIEW_LIMIT  = 3'd5;
   localparam logic [2:0] REG_SOURCE_SPAN = 3'd6;
   localparam logic [2:0] REG_MODE_BITS   = 3'd7;

   localparam logic [5:0]  FRAC_ONE   = 6'd32;
   localparam logic [13:0] LANE_ROUND = 14'd16;

   typedef struct packed {
      logic [23:0] x_start;
      logic [11:0] x_step;
      logic [23:0] y_start;
      logic [11:0] y_step;
      logic [9:0]  view_first;
      logic [9:0]  view_limit;
      logic [10:0] source_span;
      logic [1:0]  mode_bits;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [31:0]       wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

endpackage

### rtl/bsr_if.sv
interface bsr_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [15:0] source_row;
   logic [9:0]  source_col;
   logic [31:0] pixel_raw;
   logic [9:0]  out_x;
   logic [9:0]  out_y;
   modport source (output valid, func, source_row, source_col, pixel_raw, out_x, out_y,
                   input ready);
   modport sink (input valid, func, source_row, source_col, pixel_raw, out_x, out_y,
                 output ready);
endinterface

interface bsr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic       blanked;
   logic       row_missing;
   modport source (output valid, red, green, blue, alpha, blanked, row_missing,
                   input ready);
   modport sink (input valid, red, green, blue, alpha, blanked, row_missing,
                 output ready);
endinterface

### rtl/bsr_csr.sv
module bsr_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output bsr_pkg::cfg_type  cfg
);
   import bsr_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign idx = csr_paddr[4:2];
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_X_START:     cfg_in.x_start = csr_pwdata[23:0];
            REG_X_STEP:      cfg_in.x_step = csr_pwdata[11:0];
            REG_Y_START:     cfg_in.y_start = csr_pwdata[23:0];
            REG_Y_STEP:      cfg_in.y_step = csr_pwdata[11:0];
            REG_VIEW_FIRST:  cfg_in.view_first = csr_pwdata[9:0];
            REG_VIEW_LIMIT:  cfg_in.view_limit = csr_pwdata[9:0];
            REG_SOURCE_SPAN: cfg_in.source_span = csr_pwdata[10:0];
            REG_MODE_BITS:   cfg_in.mode_bits = csr_pwdata[1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_X_START:     csr_prdata = {8'd0, cfg_ff.x_start};
         REG_X_STEP:      csr_prdata = {20'd0, cfg_ff.x_step};
         REG_Y_START:     csr_prdata = {8'd0, cfg_ff.y_start};
         REG_Y_STEP:      csr_prdata = {20'd0, cfg_ff.y_step};
         REG_VIEW_FIRST:  csr_prdata = {22'd0, cfg_ff.view_first};
         REG_VIEW_LIMIT:  csr_prdata = {22'd0, cfg_ff.view_limit};
         REG_SOURCE_SPAN: csr_prdata = {21'd0, cfg_ff.source_span};
         REG_MODE_BITS:   csr_prdata = {30'd0, cfg_ff.mode_bits};
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{x_start: 24'd0, x_step: 12'd1024, y_start: 24'd0, y_step: 12'd1024,
                     view_first: 10'd0, view_limit: 10'd0, source_span: 11'd1,
                     mode_bits: 2'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

### rtl/bsr_row_mem.sv
module bsr_row_mem (
   input  logic                        clock,
   input  bsr_pkg::mem_req_type        mem_req,
   output logic [31:0]                 rdata
);
   import bsr_pkg::*;

   logic [31:0] store [2*MAX_SOURCE_COLUMNS];
   logic [31:0] rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         store[mem_req.waddr] <= mem_req.wdata;
      end
      rdata_ff <= store[mem_req.raddr];
   end
endmodule

### rtl/bsr_engine.sv
`include "bilinear_scanout_resampler_unit_macros.svh"

module bsr_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  bsr_pkg::cfg_type      cfg,
   bsr_req_if.sink               req_ch,
   bsr_rsp_if.source             rsp_ch,
   output bsr_pkg::mem_req_type  mem_req,
   input  logic [31:0]           mem_rdata
);
   import bsr_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOOK = 3'd1;
   localparam logic [2:0] S_RD0  = 3'd2;
   localparam logic [2:0] S_RD1  = 3'd3;
   localparam logic [2:0] S_RD2  = 3'd4;
   localparam logic [2:0] S_RD3  = 3'd5;
   localparam logic [2:0] S_RD4  = 3'd6;
   localparam logic [2:0] S_MIX  = 3'd7;

   function automatic logic [7:0] expand5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [31:0] decode(input logic [31:0] raw, input logic full);
      if (full) begin
         return raw;
      end
      return {expand5(raw[15:11]), expand5(raw[10:6]), expand5(raw[5:1]),
              raw[0] ? 8'hff : 8'h00};
   endfunction

   function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                         input logic [4:0] f);
      logic [5:0]  inv;
      logic [13:0] acc;
      logic [31:0] res;
      inv = FRAC_ONE - {1'b0, f};
      res = '0;
      for (int k = 0; k < 4; k++) begin
         acc = {6'd0, a[8*k +: 8]} * {8'd0, inv} + {6'd0, b[8*k +: 8]} * {9'd0, f}
               + LANE_ROUND;
         res[8*k +: 8] = acc[12:5];
      end
      return res;
   endfunction

   logic [2:0]  state_ff, state_in;
   logic [15:0] tag_ff [2];
   logic [15:0] tag_in [2];
   logic [1:0]  valid_ff, valid_in;
   logic        next_slot_ff, next_slot_in;

   logic [24:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [9:0]  ox_ff, ox_in;
   logic [9:0]  sx_ff, sx_in, nx_ff, nx_in;
   logic [4:0]  fx_ff, fx_in, fy_ff, fy_in;
   logic        s0_ff, s0_in, s1_ff, s1_in;
   logic        bilin_ff, bilin_in, need1_ff, need1_in;
   logic        blank_ff, blank_in, miss_ff, miss_in;
   logic [31:0] p_ff, p_in, h0_ff, h0_in, h1_ff, h1_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] color_ff, color_in;
   logic        rsp_blank_ff, rsp_blank_in, rsp_miss_ff, rsp_miss_in;

   logic        accept, claim, ld_hit0, ld_hit1;
   logic [14:0] sy, sx_raw;
   logic [15:0] sx_next, sy_next;
   logic        y0_hit0, y0_hit1, y1_hit0, y1_hit1, out_free;
   logic [31:0] row_mix;

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign ld_hit0 = valid_ff[0] && (tag_ff[0] == req_ch.source_row);
   assign ld_hit1 = valid_ff[1] && (tag_ff[1] == req_ch.source_row);
   assign claim = accept && (req_ch.func == FUNC_LOAD) && !ld_hit0 && !ld_hit1
                  && (req_ch.source_col == 10'd0);

   assign sx_raw = cx_ff[24:10];
   assign sy = cy_ff[24:10];
   assign sx_next = {1'b0, sx_raw} + 16'd1;
   assign sy_next = {1'b0, sy} + 16'd1;
   assign y0_hit0 = valid_ff[0] && (tag_ff[0] == {1'b0, sy});
   assign y0_hit1 = valid_ff[1] && (tag_ff[1] == {1'b0, sy});
   assign y1_hit0 = valid_ff[0] && (tag_ff[0] == sy_next);
   assign y1_hit1 = valid_ff[1] && (tag_ff[1] == sy_next);

   // Horizontal blend of the pair just read, or the left sample when replicating.
   assign row_mix = bilin_ff ? blend(p_ff, mem_rdata, fx_ff) : p_ff;

   always_comb begin
      state_in = state_ff;
      tag_in = tag_ff;
      valid_in = valid_ff;
      next_slot_in = next_slot_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      ox_in = ox_ff;
      sx_in = sx_ff;
      nx_in = nx_ff;
      fx_in = fx_ff;
      fy_in = fy_ff;
      s0_in = s0_ff;
      s1_in = s1_ff;
      bilin_in = bilin_ff;
      need1_in = need1_ff;
      blank_in = blank_ff;
      miss_in = miss_ff;
      p_in = p_ff;
      h0_in = h0_ff;
      h1_in = h1_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      color_in = color_ff;
      rsp_blank_in = rsp_blank_ff;
      rsp_miss_in = rsp_miss_ff;
      mem_req.we = 1'b0;
      mem_req.waddr = '0;
      mem_req.wdata = decode(req_ch.pixel_raw, cfg.mode_bits[0]);
      mem_req.raddr = {s0_ff, sx_ff};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_ch.func == FUNC_LOAD) begin
                  if (claim) begin
                     tag_in[next_slot_ff] = req_ch.source_row;
                     valid_in[next_slot_ff] = 1'b1;
                     next_slot_in = !next_slot_ff;
                  end
                  mem_req.we = ld_hit0 || ld_hit1 || claim;
                  mem_req.waddr = {ld_hit0 ? 1'b0 : (ld_hit1 ? 1'b1 : next_slot_ff),
                                   req_ch.source_col};
               end else begin
                  cx_in = {1'b0, cfg.x_start} + 25'({req_ch.out_x} * {cfg.x_step});
                  cy_in = {1'b0, cfg.y_start} + 25'({req_ch.out_y} * {cfg.y_step});
                  ox_in = req_ch.out_x;
                  state_in = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            bilin_in = cfg.mode_bits[1];
            fx_in = cx_ff[9:5];
            fy_in = cy_ff[9:5];
            need1_in = cfg.mode_bits[1] && (cy_ff[9:5] != 5'd0);
            blank_in = (ox_ff < cfg.view_first) || (ox_ff >= cfg.view_limit);
            miss_in = !(y0_hit0 || y0_hit1)
                      || (need1_in && !(y1_hit0 || y1_hit1));
            s0_in = !y0_hit0;
            s1_in = need1_in ? !y1_hit0 : !y0_hit0;
            sx_in = (sx_raw > 15'd1023) ? 10'd1023 : sx_raw[9:0];
            if (sx_next < {5'd0, cfg.source_span}) begin
               nx_in = (sx_next > 16'd1023) ? 10'd1023 : sx_next[9:0];
            end else begin
               nx_in = (sx_raw > 15'd1023) ? 10'd1023 : sx_raw[9:0];
            end
            state_in = (blank_in || miss_in) ? S_MIX : S_RD0;
         end
         S_RD0: begin
            mem_req.raddr = {s0_ff, sx_ff};
            state_in = S_RD1;
         end
         S_RD1: begin
            mem_req.raddr = {s0_ff, nx_ff};
            p_in = mem_rdata;
            state_in = S_RD2;
         end
         S_RD2: begin
            mem_req.raddr = {s1_ff, sx_ff};
            h0_in = row_mix;
            state_in = S_RD3;
         end
         S_RD3: begin
            mem_req.raddr = {s1_ff, nx_ff};
            p_in = mem_rdata;
            state_in = S_RD4;
         end
         S_RD4: begin
            h1_in = row_mix;
            state_in = S_MIX;
         end
         S_MIX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_blank_in = blank_ff;
               rsp_miss_in = miss_ff && !blank_ff;
               if (blank_ff || miss_ff) begin
                  color_in = 32'd0;
               end else if (need1_ff) begin
                  color_in = blend(h0_ff, h1_ff, fy_ff);
               end else begin
                  color_in = h0_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tag_ff[0] <= 16'd0;
         tag_ff[1] <= 16'd0;
         valid_ff <= 2'b00;
         next_slot_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tag_ff <= tag_in;
         valid_ff <= valid_in;
         next_slot_ff <= next_slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      ox_ff <= ox_in;
      sx_ff <= sx_in;
      nx_ff <= nx_in;
      fx_ff <= fx_in;
      fy_ff <= fy_in;
      s0_ff <= s0_in;
      s1_ff <= s1_in;
      bilin_ff <= bilin_in;
      need1_ff <= need1_in;
      blank_ff <= blank_in;
      miss_ff <= miss_in;
      p_ff <= p_in;
      h0_ff <= h0_in;
      h1_ff <= h1_in;
      color_ff <= color_in;
      rsp_blank_ff <= rsp_blank_in;
      rsp_miss_ff <= rsp_miss_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.red = color_ff[31:24];
   assign rsp_ch.green = color_ff[23:16];
   assign rsp_ch.blue = color_ff[15:8];
   assign rsp_ch.alpha = color_ff[7:0];
   assign rsp_ch.blanked = rsp_blank_ff;
   assign rsp_ch.row_missing = rsp_miss_ff;

   `BSR_ASSERT_NOW(a_flags_exclusive, rsp_valid_ff, !(rsp_blank_ff && rsp_miss_ff))
   `BSR_ASSERT_NOW(a_flagged_black, rsp_valid_ff && (rsp_blank_ff || rsp_miss_ff),
                   color_ff == 32'd0)
   `BSR_ASSERT_NEXT(a_claim_toggles, claim, next_slot_ff != $past(next_slot_ff))
   `BSR_ASSERT_NEXT(a_mix_delivers, (state_ff == S_MIX) && out_free, rsp_valid_ff)
   `BSR_ASSERT_NOW(a_no_write_busy, state_ff != S_IDLE, !mem_req.we)
endmodule

### rtl/bilinear_scanout_resampler_unit.sv
// A load word is taken only while idle; its pixel is written to the row store at the accept
// edge if its row holds a slot or, at column 0, claims one. A request does a tag lookup, four
// reads through the single read port of the row store and the vertical blend, and takes no
// new word until its result is registered; a blanked column or a missing row skips the reads.
// A result waits in an output register; the next load may be taken meanwhile.
// Synchronous active-high reset clears row tags, valid bits, slot pointer and result valid.
module bilinear_scanout_resampler_unit (
   input  logic        clock,
   input  logic        reset,
   bsr_req_if.sink     req_ch,
   bsr_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bsr_pkg::*;

   cfg_type     cfg;
   mem_req_type mem_req;
   logic [31:0] mem_rdata;

   bsr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bsr_row_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   bsr_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );
endmodule
